/* hdl/lrfp_pkg.sv */
// Shared types, byte codes and event codes of the lens reply frame parser.
package lrfp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned FrameLenW  = 8;
  localparam int unsigned EventW     = 3;
  localparam int unsigned ValueW     = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [FrameLenW-1:0] FrameLengthReset = 8'd7;
  localparam logic                 DataModeReset    = 1'b1;

  localparam logic [ByteW-1:0] SyncByte     = 8'hFF;
  localparam logic [ByteW-1:0] IdByte       = 8'h01;
  localparam logic [ByteW-1:0] CmdFocusByte = 8'h8D;
  localparam logic [ByteW-1:0] CmdZoomByte  = 8'h5D;

  localparam logic [FrameLenW-1:0] DataIdPos  = 8'd6;
  localparam logic [FrameLenW-1:0] PlainIdPos = 8'd3;
  localparam logic [FrameLenW-1:0] CmdPos     = 8'd4;
  localparam logic [FrameLenW-1:0] HighPos    = 8'd3;
  localparam logic [FrameLenW-1:0] LowPos     = 8'd2;
  localparam logic [FrameLenW-1:0] CheckPos   = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameLength = 1'd0,
    CfgDataMode    = 1'd1
  } cfg_reg_e;

  typedef enum logic [EventW-1:0] {
    EvFocus  = 3'd0,
    EvZoom   = 3'd1,
    EvSyncEr = 3'd2,
    EvIdEr   = 3'd3,
    EvCmdEr  = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    CmdNone  = 2'd0,
    CmdFocus = 2'd1,
    CmdZoom  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [FrameLenW-1:0] bytes_left;
    logic [1:0]           pending_command;
    logic [ByteW-1:0]     value_high;
    logic [ByteW-1:0]     value_low;
  } parse_state_t;

  typedef struct packed {
    logic              emit;
    event_e            code;
    logic [ValueW-1:0] value;
  } parse_result_t;

endpackage

/* hdl/lrfp_step.sv */
// Next-state and result logic for one received byte of a reply frame.
module lrfp_step import lrfp_pkg::*; (
  input  logic [ByteW-1:0]     rx_byte_i,
  input  logic [FrameLenW-1:0] frame_length_i,
  input  logic                 data_mode_i,
  input  parse_state_t         state_i,
  output parse_state_t         state_o,
  output parse_result_t        result_o
);

  logic [FrameLenW-1:0] id_pos;
  logic [FrameLenW-1:0] base;
  logic [FrameLenW-1:0] dec;
  logic                 err;
  event_e               err_code;
  parse_state_t         nxt;

  assign id_pos = data_mode_i ? DataIdPos : PlainIdPos;

  always_comb begin
    nxt      = state_i;
    base     = state_i.bytes_left;
    err      = 1'b0;
    err_code = EvSyncEr;
    if (state_i.bytes_left == '0) begin
      base = (frame_length_i == '0) ? FrameLenW'(1) : frame_length_i;
      if (rx_byte_i != SyncByte) begin
        err      = 1'b1;
        err_code = EvSyncEr;
      end
    end else if (state_i.bytes_left == id_pos) begin
      if (rx_byte_i != IdByte) begin
        err      = 1'b1;
        err_code = EvIdEr;
      end
    end else if (state_i.bytes_left == CheckPos) begin
      nxt = state_i;
    end else if (!data_mode_i) begin
      nxt = state_i;
    end else if (state_i.bytes_left == HighPos) begin
      nxt.value_high = rx_byte_i;
    end else if (state_i.bytes_left == LowPos) begin
      nxt.value_low = rx_byte_i;
    end else if (state_i.bytes_left == CmdPos) begin
      if (rx_byte_i == CmdFocusByte) begin
        nxt.pending_command = CmdFocus;
      end else if (rx_byte_i == CmdZoomByte) begin
        nxt.pending_command = CmdZoom;
      end else begin
        err      = 1'b1;
        err_code = EvCmdEr;
      end
    end
  end

  assign dec = base - FrameLenW'(1);

  always_comb begin
    state_o        = nxt;
    result_o.emit  = 1'b0;
    result_o.code  = EvFocus;
    result_o.value = '0;
    if (err) begin
      state_o                 = state_i;
      state_o.bytes_left      = '0;
      result_o.emit           = 1'b1;
      result_o.code           = err_code;
    end else begin
      state_o.bytes_left = dec;
      if ((dec == '0) && data_mode_i) begin
        if (nxt.pending_command == CmdFocus) begin
          state_o.pending_command = CmdNone;
          result_o.emit           = 1'b1;
          result_o.code           = EvFocus;
          result_o.value          = {nxt.value_high, nxt.value_low};
        end else if (nxt.pending_command == CmdZoom) begin
          state_o.pending_command = CmdNone;
          result_o.emit           = 1'b1;
          result_o.code           = EvZoom;
          result_o.value          = {nxt.value_high, nxt.value_low};
        end
      end
    end
  end

endmodule

/* hdl/lens_reply_frame_parser_core.sv */
// Top level of the lens reply frame parser: input register, frame state and result register.
//
// The input channel carries one received byte per beat (in_valid_i, in_stall_o,
// rx_byte_i). The output channel carries one event per beat (out_valid_o,
// out_stall_i, event_code_o, position_value_o): a focus or zoom value at the
// end of a data-mode frame, or a sync, ID or command error that drops a frame.
// Most bytes give no event.
// A byte accepted into the input register is held there until the result register
// can advance; it is then parsed against the frame state, and its event, if any, is
// registered into the result register and shown from there.
// One byte is accepted every cycle while in_stall_o is low; the frame state is
// one counter and three small registers updated by a single pass of compare logic.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more byte; in_stall_o rises only when both are full.
// Reset empties both registers, sets the frame length to 7 and data mode on,
// and clears the frame state so the block waits for a sync byte.
// The configuration port writes frame_length (index 0) and data_mode
// (index 1) at any edge with cfg_we_i high.
module lens_reply_frame_parser_core import lrfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [EventW-1:0]   event_code_o,
  output logic [ValueW-1:0]   position_value_o
);

  logic [FrameLenW-1:0] frame_length_q;
  logic                 data_mode_q;
  logic                 in_full_q;
  logic [ByteW-1:0]     byte_q;
  parse_state_t         state_q;
  parse_state_t         state_d;
  parse_result_t        result_d;
  logic                 out_valid_q;
  logic [EventW-1:0]    code_q;
  logic [ValueW-1:0]    value_q;
  logic                 advance;
  logic                 in_accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_full_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= FrameLengthReset;
      data_mode_q    <= DataModeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFrameLength: frame_length_q <= cfg_wdata_i[FrameLenW-1:0];
        CfgDataMode:    data_mode_q    <= cfg_wdata_i[0];
        default:        data_mode_q    <= data_mode_q;
      endcase
    end
  end

  lrfp_step u_step (
    .rx_byte_i      (byte_q),
    .frame_length_i (frame_length_q),
    .data_mode_i    (data_mode_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_accept) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_full_q && result_d.emit;
      if (in_full_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_full_q && result_d.emit) begin
      code_q  <= result_d.code;
      value_q <= result_d.value;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_code_o     = code_q;
  assign position_value_o = value_q;

endmodule

/* hdl/lrfp_checker.sv */
// Port-level checker for the lens reply frame parser and its bind statement.
module lrfp_checker import lrfp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [EventW-1:0] event_code_o,
  input logic [ValueW-1:0] position_value_o
);

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_code_o <= EvCmdEr))
    else $error("Event code out of range.");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_code_o == EvSyncEr || event_code_o == EvIdEr ||
                     event_code_o == EvCmdEr)) |-> (position_value_o == '0))
    else $error("Error event carries a nonzero value.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("Result beat without a byte accepted two cycles earlier.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(event_code_o) && $stable(position_value_o)))
    else $error("Stalled result beat changed.");

endmodule

bind lens_reply_frame_parser_core lrfp_checker u_lrfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .event_code_o     (event_code_o),
  .position_value_o (position_value_o)
);
